[sv/lsq_pkg.sv]
// Load/store queue package: command codes, controller states, register indexes,
// default sizes and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package lsq_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int TAG_BITS_DEF = 8;
    localparam int MAX_REPORTS  = 16;
    localparam int REP_IW       = $clog2(MAX_REPORTS);
    localparam int REP_CW       = $clog2(MAX_REPORTS + 1);

    localparam logic [3:0] MAX_OPS_RESET      = 4'd2;
    localparam logic [7:0] LOAD_LATENCY_RESET = 8'd3;

    localparam logic REG_MAX_OPS      = 1'b0;
    localparam logic REG_LOAD_LATENCY = 1'b1;

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_ADDR_RDY = 3'd1,
        CMD_CANCEL  = 3'd2,
        CMD_RELEASE = 3'd3,
        CMD_TICK    = 3'd4,
        CMD_FLUSH   = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP,
        ST_RESP,
        ST_SCAN,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic latch;
        logic do_op;
        logic scan_step;
        logic rep_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic scan_last;
        logic rep_last;
    } dp_status_t;

endpackage

[sv/lsq_ctrl.sv]
// Load/store queue controller: sequences accept, single-step commands, the
// tick scan and the report beats. Depends on lsq_pkg.
`timescale 1ns / 1ps

module lsq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  lsq_pkg::dp_status_t status,
    output lsq_pkg::ctrl_cmd_t  cmd,
    output logic               busy,
    output logic               strobe
);
    import lsq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        strobe     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = status.is_tick ? ST_SCAN : ST_OP;
                end
            end
            ST_OP:
            begin
                cmd.do_op  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                strobe     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                strobe       = 1'b1;
                cmd.rep_step = 1'b1;
                if (status.rep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/lsq_datapath.sv]
// Load/store queue datapath: entry store, fill and stall counters, config
// registers, per-slot tick scan with in-place compaction, report buffer.
// Depends on lsq_pkg.
`timescale 1ns / 1ps

module lsq_datapath #(
    parameter int SLOTS    = lsq_pkg::SLOTS_DEF,
    parameter int TAG_BITS = lsq_pkg::TAG_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lsq_pkg::ctrl_cmd_t  cmd,
    output lsq_pkg::dp_status_t status,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic [2:0]         command,
    input  logic [7:0]         tag,
    input  logic               is_load,
    input  logic               is_store,
    input  logic               wide_op,
    input  logic [31:0]        now_cycle,
    output logic               accepted,
    output logic               done_valid,
    output logic [7:0]         done_tag,
    output logic               last,
    output logic [5:0]         fill_count,
    output logic [31:0]        stall_count
);
    import lsq_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW = $clog2(SLOTS + 4);

    cmd_t                cmd_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                ld_reg;
    logic                st_reg;
    logic                wide_reg;
    logic [31:0]         now_reg;
    logic                acc_reg;

    logic [3:0]          max_ops_reg;
    logic [7:0]          lat_reg;

    logic [SLOTS-1:0]    valid_reg;
    logic                store_reg [SLOTS];
    logic [TAG_BITS-1:0] etag_reg  [SLOTS];
    logic                ewide_reg [SLOTS];
    logic                ardy_reg  [SLOTS];
    logic                canc_reg  [SLOTS];
    logic [31:0]         done_reg  [SLOTS];

    logic [FW-1:0]       filled_reg;
    logic [31:0]         stalls_reg;

    logic [IW-1:0]       scan_reg;
    logic [IW-1:0]       wr_reg;
    logic [4:0]          ops_reg;
    logic                sok_reg;
    logic [REP_CW-1:0]   nrep_reg;
    logic [REP_IW-1:0]   rep_i_reg;
    logic [TAG_BITS-1:0] rep_tag_reg [MAX_REPORTS];

    // add, release
    logic [IW-1:0]       f1;
    logic [IW-1:0]       f2;
    logic [IW-1:0]       rel_idx;
    logic                rel_ok;
    logic                found1;
    logic [FW-1:0]       need;
    logic                add_any;
    logic                add_ok;
    logic [IW-1:0]       st_slot;

    // scan
    logic                sc_v;
    logic                sc_st;
    logic                sc_wide;
    logic                sc_ardy;
    logic                sc_canc;
    logic [31:0]         sc_done;
    logic                due;
    logic                ret_ld;
    logic                remove;
    logic                keep;
    logic [31:0]         new_done;
    logic [4:0]          ops_next;
    logic                sok_next;
    logic [7:0]          lat_eff;
    logic [32:0]         ld_sum;
    logic [31:0]         ld_done;
    logic [FW-1:0]       sc_weight;
    logic [FW-1:0]       rel_weight;
    logic [15:0]         tag16;

    always_comb
    begin
        found1  = 1'b0;
        f1      = '0;
        f2      = '0;
        rel_ok  = 1'b0;
        rel_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!valid_reg[i])
            begin
                if (found1 && f2 == f1)
                begin
                    f2 = IW'(i);
                end
                if (!found1)
                begin
                    f1     = IW'(i);
                    f2     = IW'(i);
                    found1 = 1'b1;
                end
            end
            if (!rel_ok && valid_reg[i] && etag_reg[i] == tag_reg)
            begin
                rel_ok  = 1'b1;
                rel_idx = IW'(i);
            end
        end
        need    = FW'(ld_reg) + (st_reg ? (wide_reg ? FW'(2) : FW'(1)) : FW'(0));
        add_any = ld_reg | st_reg;
        add_ok  = add_any && (filled_reg + need <= FW'(SLOTS));
        st_slot = ld_reg ? f2 : f1;
        rel_weight = (store_reg[rel_idx] && ewide_reg[rel_idx]) ? FW'(2) : FW'(1);
    end

    always_comb
    begin
        sc_v    = valid_reg[scan_reg];
        sc_st   = store_reg[scan_reg];
        sc_wide = ewide_reg[scan_reg];
        sc_ardy = ardy_reg[scan_reg];
        sc_canc = canc_reg[scan_reg];
        sc_done = done_reg[scan_reg];
        due     = (sc_done != 32'd0) && (sc_done <= now_reg);
        ret_ld  = sc_v && !sc_canc && due && !sc_st && (nrep_reg < REP_CW'(MAX_REPORTS));
        remove  = sc_v && (sc_canc || (due && sc_st) || ret_ld);
        keep    = sc_v && !remove;
        sc_weight = (sc_st && sc_wide) ? FW'(2) : FW'(1);
        lat_eff = (lat_reg == 8'd0) ? 8'd1 : lat_reg;
        ld_sum  = {1'b0, now_reg} + 33'(lat_eff);
        ld_done = ld_sum[32] ? 32'hFFFF_FFFF : ld_sum[31:0];
        new_done = sc_done;
        ops_next = ops_reg;
        sok_next = sok_reg;
        if (keep && (ops_reg < {1'b0, max_ops_reg}) && sc_done == 32'd0)
        begin
            if (sc_st)
            begin
                if (sok_reg)
                begin
                    if (!sc_ardy)
                    begin
                        sok_next = 1'b0;
                    end
                    else if (sc_wide)
                    begin
                        if (({1'b0, max_ops_reg} - ops_reg) >= 5'd2)
                        begin
                            new_done = 32'd1;
                            ops_next = ops_reg + 5'd2;
                        end
                        else
                        begin
                            sok_next = 1'b0;
                        end
                    end
                    else
                    begin
                        new_done = 32'd1;
                        ops_next = ops_reg + 5'd1;
                    end
                end
            end
            else if (sc_ardy)
            begin
                new_done = ld_done;
                ops_next = ops_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg     <= CMD_ADD;
            acc_reg     <= 1'b0;
            max_ops_reg <= MAX_OPS_RESET;
            lat_reg     <= LOAD_LATENCY_RESET;
            valid_reg   <= '0;
            filled_reg  <= '0;
            stalls_reg  <= '0;
            scan_reg    <= '0;
            wr_reg      <= '0;
            ops_reg     <= '0;
            sok_reg     <= 1'b1;
            nrep_reg    <= '0;
            rep_i_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_MAX_OPS)
                begin
                    max_ops_reg <= cfg_data[3:0];
                end
                else
                begin
                    lat_reg <= cfg_data;
                end
            end
            if (cmd.latch)
            begin
                cmd_reg   <= cmd_t'(command);
                acc_reg   <= 1'b0;
                scan_reg  <= '0;
                wr_reg    <= '0;
                ops_reg   <= '0;
                sok_reg   <= 1'b1;
                nrep_reg  <= '0;
                rep_i_reg <= '0;
            end
            if (cmd.do_op)
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (!add_any)
                        begin
                            acc_reg <= 1'b1;
                        end
                        else if (!add_ok)
                        begin
                            if (stalls_reg != 32'hFFFF_FFFF)
                            begin
                                stalls_reg <= stalls_reg + 32'd1;
                            end
                        end
                        else
                        begin
                            acc_reg    <= 1'b1;
                            filled_reg <= filled_reg + need;
                            if (ld_reg)
                            begin
                                valid_reg[f1] <= 1'b1;
                            end
                            if (st_reg)
                            begin
                                valid_reg[st_slot] <= 1'b1;
                            end
                        end
                    end
                    CMD_RELEASE:
                    begin
                        if (rel_ok)
                        begin
                            valid_reg[rel_idx] <= 1'b0;
                            filled_reg <= (filled_reg >= rel_weight) ?
                                          filled_reg - rel_weight : '0;
                        end
                    end
                    CMD_FLUSH:
                    begin
                        valid_reg  <= '0;
                        filled_reg <= '0;
                    end
                    default:
                    begin
                        acc_reg <= 1'b0;
                    end
                endcase
            end
            if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + IW'(1);
                ops_reg  <= ops_next;
                sok_reg  <= sok_next;
                if (remove)
                begin
                    filled_reg <= (filled_reg >= sc_weight) ? filled_reg - sc_weight : '0;
                end
                if (ret_ld)
                begin
                    nrep_reg <= nrep_reg + REP_CW'(1);
                end
                if (!keep || wr_reg != scan_reg)
                begin
                    valid_reg[scan_reg] <= 1'b0;
                end
                if (keep)
                begin
                    valid_reg[wr_reg] <= 1'b1;
                    wr_reg <= wr_reg + IW'(1);
                end
            end
            if (cmd.rep_step)
            begin
                rep_i_reg <= rep_i_reg + REP_IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            tag_reg  <= TAG_BITS'(16'(tag));
            ld_reg   <= is_load;
            st_reg   <= is_store;
            wide_reg <= wide_op;
            now_reg  <= now_cycle;
        end
        if (cmd.do_op)
        begin
            case (cmd_reg)
                CMD_ADD:
                begin
                    if (add_ok && ld_reg)
                    begin
                        store_reg[f1] <= 1'b0;
                        etag_reg[f1]  <= tag_reg;
                        ewide_reg[f1] <= wide_reg;
                        ardy_reg[f1]  <= 1'b0;
                        canc_reg[f1]  <= 1'b0;
                        done_reg[f1]  <= 32'd0;
                    end
                    if (add_ok && st_reg)
                    begin
                        store_reg[st_slot] <= 1'b1;
                        etag_reg[st_slot]  <= tag_reg;
                        ewide_reg[st_slot] <= wide_reg;
                        ardy_reg[st_slot]  <= 1'b0;
                        canc_reg[st_slot]  <= 1'b0;
                        done_reg[st_slot]  <= 32'd0;
                    end
                end
                CMD_ADDR_RDY:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (valid_reg[i] && etag_reg[i] == tag_reg)
                        begin
                            ardy_reg[i] <= 1'b1;
                        end
                    end
                end
                CMD_CANCEL:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (valid_reg[i] && etag_reg[i] == tag_reg)
                        begin
                            canc_reg[i] <= 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.scan_step)
        begin
            if (keep)
            begin
                store_reg[wr_reg] <= sc_st;
                etag_reg[wr_reg]  <= etag_reg[scan_reg];
                ewide_reg[wr_reg] <= sc_wide;
                ardy_reg[wr_reg]  <= sc_ardy;
                canc_reg[wr_reg]  <= sc_canc;
                done_reg[wr_reg]  <= new_done;
            end
            if (ret_ld)
            begin
                rep_tag_reg[nrep_reg[REP_IW-1:0]] <= etag_reg[scan_reg];
            end
        end
    end

    always_comb
    begin
        tag16           = 16'(rep_tag_reg[rep_i_reg]);
        status.is_tick  = (command == CMD_TICK);
        status.scan_last = (scan_reg == IW'(SLOTS - 1));
        status.rep_last = (nrep_reg == '0) ||
                          (REP_CW'(rep_i_reg) == nrep_reg - REP_CW'(1));
        fill_count      = 6'(filled_reg);
        stall_count     = stalls_reg;
        if (cmd_reg == CMD_TICK)
        begin
            accepted   = 1'b0;
            done_valid = (nrep_reg != '0);
            done_tag   = (nrep_reg != '0) ? tag16[7:0] : 8'd0;
            last       = status.rep_last;
        end
        else
        begin
            accepted   = acc_reg;
            done_valid = 1'b0;
            done_tag   = 8'd0;
            last       = 1'b1;
        end
    end

endmodule

[sv/load_store_queue_core.sv]
// Load/store queue top level: controller and datapath.
// Non-tick commands: states OP, then RESP, which strobes the result beat; no new
// item is taken until back in IDLE. Tick: one slot a cycle through the scan, then
// one beat per retiring load (one beat if none).
// Reset empties the queue, clears the counters, loads max_ops 2 and load_latency 3.
// Results are strobed for one cycle each; the receiver cannot stall.
`timescale 1ns / 1ps

module load_store_queue_core #(
    parameter int SLOTS    = lsq_pkg::SLOTS_DEF,
    parameter int TAG_BITS = lsq_pkg::TAG_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic [2:0]  command,
    input  logic [7:0]  tag,
    input  logic        is_load,
    input  logic        is_store,
    input  logic        wide_op,
    input  logic [31:0] now_cycle,
    output logic        strobe,
    output logic        accepted,
    output logic        done_valid,
    output logic [7:0]  done_tag,
    output logic        last,
    output logic [5:0]  fill_count,
    output logic [31:0] stall_count
);
    import lsq_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    lsq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe)
    );

    lsq_datapath #(
        .SLOTS    (SLOTS),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .command     (command),
        .tag         (tag),
        .is_load     (is_load),
        .is_store    (is_store),
        .wide_op     (wide_op),
        .now_cycle   (now_cycle),
        .accepted    (accepted),
        .done_valid  (done_valid),
        .done_tag    (done_tag),
        .last        (last),
        .fill_count  (fill_count),
        .stall_count (stall_count)
    );

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result beat outside a busy item");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && done_valid) |-> !accepted)
        else $error("load report flagged as accepted add");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (7'(fill_count) <= 7'(SLOTS)))
        else $error("fill count beyond capacity");

endmodule

[tb/load_store_queue_core_test.sv]
// Self-checking testbench for load_store_queue_core: directed and random command beats,
// predicted by a behavioural copy of the queue and compared field by field on each strobe.
// Depends on lsq_pkg and load_store_queue_core.
`timescale 1ns / 1ps

module load_store_queue_core_test;
    import lsq_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic        accepted;
        logic        done_valid;
        logic [7:0]  done_tag;
        logic        last;
        logic [5:0]  fill;
        logic [31:0] stalls;
    } lsq_beat_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cfg_write;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic [2:0]  command;
    logic [7:0]  tag;
    logic        is_load;
    logic        is_store;
    logic        wide_op;
    logic [31:0] now_cycle;
    logic        strobe;
    logic        accepted;
    logic        done_valid;
    logic [7:0]  done_tag;
    logic        last;
    logic [5:0]  fill_count;
    logic [31:0] stall_count;

    load_store_queue_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .command(command), .tag(tag), .is_load(is_load), .is_store(is_store),
        .wide_op(wide_op), .now_cycle(now_cycle), .strobe(strobe),
        .accepted(accepted), .done_valid(done_valid), .done_tag(done_tag),
        .last(last), .fill_count(fill_count), .stall_count(stall_count)
    );

    // shadow queue
    logic        sh_valid [NSLOT];
    logic        sh_store [NSLOT];
    logic        sh_wide  [NSLOT];
    logic        sh_ready [NSLOT];
    logic        sh_cancel[NSLOT];
    logic [7:0]  sh_tag   [NSLOT];
    logic [31:0] sh_done  [NSLOT];
    int unsigned sh_filled;
    logic [31:0] sh_stalls;
    logic [3:0]  sh_max_ops;
    logic [7:0]  sh_latency;

    lsq_beat_t   pending_beats[$];
    int          error_count;
    int          idle_cycles;
    logic [31:0] clock_now;
    bit          burst_mode;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned slot_weight(int i);
        return (sh_store[i] && sh_wide[i]) ? 2 : 1;
    endfunction

    function automatic void clear_slot(int i);
        sh_valid[i]  = 1'b0;
        sh_store[i]  = 1'b0;
        sh_wide[i]   = 1'b0;
        sh_ready[i]  = 1'b0;
        sh_cancel[i] = 1'b0;
        sh_tag[i]    = 8'd0;
        sh_done[i]   = 32'd0;
    endfunction

    function automatic void free_slot(int i);
        int unsigned w;
        w = slot_weight(i);
        sh_filled = (sh_filled >= w) ? sh_filled - w : 0;
        clear_slot(i);
    endfunction

    function automatic void place_slot(logic st, logic [7:0] t, logic wd);
        for (int i = 0; i < NSLOT; i++)
        begin
            if (!sh_valid[i])
            begin
                clear_slot(i);
                sh_valid[i] = 1'b1;
                sh_store[i] = st;
                sh_tag[i]   = t;
                sh_wide[i]  = wd;
                sh_filled  += slot_weight(i);
                return;
            end
        end
    endfunction

    function automatic lsq_beat_t make_beat(logic acc, logic dv, logic [7:0] dt, logic lst);
        lsq_beat_t b;
        b.accepted   = acc;
        b.done_valid = dv;
        b.done_tag   = dt;
        b.last       = lst;
        b.fill       = sh_filled[5:0];
        b.stalls     = sh_stalls;
        return b;
    endfunction

    function automatic void predict_queue(logic [2:0] cmd, logic [7:0] t, logic ld,
                                          logic st, logic wd, logic [31:0] now);
        logic        acc;
        logic [7:0]  reps[$];
        int unsigned need;
        int unsigned ops;
        int unsigned lat;
        int          w;
        bit          stores_ok;
        logic [32:0] due;
        acc = 1'b0;
        case (cmd)
            CMD_ADD:
            begin
                if (!ld && !st)
                    acc = 1'b1;
                else
                begin
                    need = (ld ? 1 : 0) + (st ? (wd ? 2 : 1) : 0);
                    if (sh_filled + need > NSLOT)
                    begin
                        if (sh_stalls != 32'hFFFF_FFFF)
                            sh_stalls++;
                    end
                    else
                    begin
                        if (ld)
                            place_slot(1'b0, t, wd);
                        if (st)
                            place_slot(1'b1, t, wd);
                        acc = 1'b1;
                    end
                end
            end
            CMD_ADDR_RDY, CMD_CANCEL:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (sh_valid[i] && sh_tag[i] == t)
                    begin
                        if (cmd == CMD_ADDR_RDY)
                            sh_ready[i] = 1'b1;
                        else
                            sh_cancel[i] = 1'b1;
                    end
            end
            CMD_RELEASE:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (sh_valid[i] && sh_tag[i] == t)
                    begin
                        free_slot(i);
                        break;
                    end
            end
            CMD_TICK:
            begin
                ops = 0;
                stores_ok = 1'b1;
                lat = (sh_latency == 8'd0) ? 1 : sh_latency;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (!sh_valid[i])
                        continue;
                    if (sh_cancel[i])
                    begin
                        free_slot(i);
                        continue;
                    end
                    if (sh_done[i] != 0 && sh_done[i] <= now)
                    begin
                        if (!sh_store[i])
                        begin
                            if (reps.size() >= MAX_REPORTS)
                                continue;
                            reps.push_back(sh_tag[i]);
                        end
                        free_slot(i);
                    end
                end
                for (int i = 0; i < NSLOT && ops < sh_max_ops; i++)
                begin
                    if (!sh_valid[i] || sh_done[i] != 0)
                        continue;
                    if (sh_store[i])
                    begin
                        if (!stores_ok)
                            continue;
                        if (!sh_ready[i])
                            stores_ok = 1'b0;
                        else if (sh_wide[i])
                        begin
                            if (sh_max_ops - ops >= 2)
                            begin
                                sh_done[i] = 32'd1;
                                ops += 2;
                            end
                            else
                                stores_ok = 1'b0;
                        end
                        else
                        begin
                            sh_done[i] = 32'd1;
                            ops++;
                        end
                    end
                    else if (sh_ready[i])
                    begin
                        due = {1'b0, now} + lat;
                        sh_done[i] = due[32] ? 32'hFFFF_FFFF : due[31:0];
                        ops++;
                    end
                end
                w = 0;
                for (int i = 0; i < NSLOT; i++)
                    if (sh_valid[i])
                    begin
                        if (w != i)
                        begin
                            sh_valid[w]  = sh_valid[i];
                            sh_store[w]  = sh_store[i];
                            sh_tag[w]    = sh_tag[i];
                            sh_wide[w]   = sh_wide[i];
                            sh_ready[w]  = sh_ready[i];
                            sh_cancel[w] = sh_cancel[i];
                            sh_done[w]   = sh_done[i];
                            clear_slot(i);
                        end
                        w++;
                    end
                if (reps.size() == 0)
                    pending_beats.push_back(make_beat(1'b0, 1'b0, 8'd0, 1'b1));
                else
                    foreach (reps[k])
                        pending_beats.push_back(make_beat(1'b0, 1'b1, reps[k],
                                                          k == reps.size() - 1));
                return;
            end
            CMD_FLUSH:
            begin
                for (int i = 0; i < NSLOT; i++)
                    clear_slot(i);
                sh_filled = 0;
            end
            default: ;
        endcase
        pending_beats.push_back(make_beat(acc, 1'b0, 8'd0, 1'b1));
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        lsq_beat_t want;
        if (rst_n && strobe)
        begin
            if (pending_beats.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want = pending_beats.pop_front();
                if (accepted !== want.accepted)
                    report_mismatch($sformatf("accepted %b, want %b", accepted, want.accepted));
                if (done_valid !== want.done_valid)
                    report_mismatch($sformatf("done_valid %b, want %b", done_valid,
                                              want.done_valid));
                if (done_tag !== want.done_tag)
                    report_mismatch($sformatf("done_tag %0d, want %0d", done_tag, want.done_tag));
                if (last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", last, want.last));
                if (fill_count !== want.fill)
                    report_mismatch($sformatf("fill_count %0d, want %0d", fill_count, want.fill));
                if (stall_count !== want.stalls)
                    report_mismatch($sformatf("stall_count %0d, want %0d", stall_count,
                                              want.stalls));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_command(input logic [2:0] cmd, input logic [7:0] t, input logic ld,
                                input logic st, input logic wd, input logic [31:0] now);
        command   <= cmd;
        tag       <= t;
        is_load   <= ld;
        is_store  <= st;
        wide_op   <= wd;
        now_cycle <= now;
        start     <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_queue(cmd, t, ld, st, wd, now);
    endtask

    task automatic hold_off(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    task automatic drain_queue();
        start <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] value);
        drain_queue();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_MAX_OPS)
            sh_max_ops = value[3:0];
        else
            sh_latency = value;
    endtask

    task automatic test_directed();
        send_command(CMD_FLUSH, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0);
        send_command(CMD_ADD, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0);
        send_command(CMD_ADD, 8'hFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_command(CMD_ADDR_RDY, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0);
        send_command(CMD_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0);
        send_command(CMD_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0);
        send_command(CMD_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 32'd5);
        for (int i = 1; i <= 8; i++)
            send_command(CMD_ADD, 8'(i), 1'b0, 1'b1, 1'b1, 32'd0);
        send_command(CMD_ADD, 8'd9, 1'b1, 1'b0, 1'b0, 32'd0);
        send_command(CMD_CANCEL, 8'd1, 1'b0, 1'b0, 1'b0, 32'd0);
        send_command(CMD_RELEASE, 8'd2, 1'b0, 1'b0, 1'b0, 32'd0);
        send_command(CMD_RELEASE, 8'd200, 1'b0, 1'b0, 1'b0, 32'd0);
        send_command(CMD_CANCEL, 8'd201, 1'b0, 1'b0, 1'b0, 32'd0);
        send_command(CMD_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 32'd1);
        send_command(CMD_SPARE_LO, 8'd3, 1'b1, 1'b1, 1'b1, 32'd7);
        send_command(CMD_SPARE_HI, 8'd4, 1'b1, 1'b0, 1'b0, 32'd7);
        send_command(CMD_FLUSH, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0);
        send_command(CMD_ADD, 8'd9, 1'b1, 1'b0, 1'b0, 32'd0);
        send_command(CMD_ADDR_RDY, 8'd9, 1'b0, 1'b0, 1'b0, 32'd0);
        send_command(CMD_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFE);
        send_command(CMD_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        hold_off(1);
    endtask

    task automatic test_report_limit();
        write_register(REG_MAX_OPS, 8'd8);
        send_command(CMD_FLUSH, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0);
        for (int i = 0; i < NSLOT; i++)
            send_command(CMD_ADD, 8'hA5, 1'b1, 1'b0, 1'b0, 32'd0);
        send_command(CMD_ADDR_RDY, 8'hA5, 1'b0, 1'b0, 1'b0, 32'd0);
        send_command(CMD_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 32'd10);
        send_command(CMD_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 32'd10);
        send_command(CMD_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 32'd100);
        hold_off(1);
    endtask

    task automatic test_random_phase(input logic [7:0] ops, input logic [7:0] lat,
                                     input int count);
        int          r;
        logic [2:0]  cmd;
        logic [7:0]  t;
        logic        ld;
        logic        st;
        write_register(REG_MAX_OPS, ops);
        write_register(REG_LOAD_LATENCY, lat);
        for (int n = 0; n < count; n++)
        begin
            if (n % 20 == 0)
                burst_mode = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 35)
                cmd = CMD_ADD;
            else if (r < 55)
                cmd = CMD_ADDR_RDY;
            else if (r < 60)
                cmd = CMD_CANCEL;
            else if (r < 67)
                cmd = CMD_RELEASE;
            else if (r < 95)
                cmd = CMD_TICK;
            else if (r < 97)
                cmd = CMD_FLUSH;
            else
                cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
            t = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            ld = (r < 50) || (r >= 80 && r < 95);
            st = (r >= 50 && r < 95);
            if (cmd == CMD_TICK)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    clock_now = clock_now + $urandom_range(0, 3);
                else if (r < 95)
                    clock_now = clock_now + $urandom_range(4, 300);
                else
                    clock_now = $urandom;
            end
            send_command(cmd, t, ld, st, 1'($urandom_range(0, 1)),
                         (cmd == CMD_TICK) ? clock_now : 32'($urandom));
            if ($urandom_range(0, 99) < 3)
                drain_queue();
            else
                hold_off(pick_gap());
        end
        burst_mode = 1'b0;
        hold_off(1);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= 1'b0;
        cfg_data  <= 8'd0;
        command   <= CMD_ADD;
        tag       <= 8'd0;
        is_load   <= 1'b0;
        is_store  <= 1'b0;
        wide_op   <= 1'b0;
        now_cycle <= 32'd0;
        error_count = 0;
        idle_cycles = 0;
        clock_now   = 32'd0;
        burst_mode  = 1'b0;
        for (int i = 0; i < NSLOT; i++)
            clear_slot(i);
        sh_filled  = 0;
        sh_stalls  = 32'd0;
        sh_max_ops = MAX_OPS_RESET;
        sh_latency = LOAD_LATENCY_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_report_limit();
        test_random_phase(8'd2, 8'd3, 30);
        test_random_phase(8'd0, 8'd0, 15);
        test_random_phase(8'd15, 8'd255, 30);
        test_random_phase(8'd1, 8'd1, 30);
        test_random_phase(8'd8, 8'd5, 35);
        test_random_phase(8'd4, 8'd2, 30);

        start <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
sv/lsq_pkg.sv
sv/lsq_ctrl.sv
sv/lsq_datapath.sv
sv/load_store_queue_core.sv
tb/load_store_queue_core_test.sv
